### rtl/wsdf_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; the other files that use it refer to it by scoped names.
package wsdf_pkg;

  typedef enum logic [1:0] {
    KindPayload = 2'd0,
    KindEmpty   = 2'd1,
    KindReject  = 2'd2
  } kind_e;

  // Header byte 0 reserved bits, the 7-bit length codes, and header field byte counts.
  localparam logic [7:0] RsvMask    = 8'h70;
  localparam logic [6:0] Len7Max    = 7'd125;
  localparam logic [6:0] Len16Code  = 7'd126;
  localparam logic [3:0] Ext16Bytes = 4'd2;
  localparam logic [3:0] Ext64Bytes = 4'd8;
  localparam logic [3:0] KeyBytes   = 4'd4;

  localparam int unsigned QueueDepth = 4;

  // One classified result on its way from the parser to the output stage.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  raw;
    logic [7:0]  key;
    logic        last;
    logic        fin;
    logic [3:0]  opcode;
    logic        masked;
  } entry_t;

endpackage

### rtl/wsdf_if.sv
// Valid/ready channel interfaces for the deframer's byte input and result output.
// Depends on nothing.
interface wsdf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

interface wsdf_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] payload_byte;
  logic       last_of_frame;
  logic       fin_flag;
  logic [3:0] frame_opcode;
  logic       was_masked;

  modport source (output valid, output kind, output payload_byte, output last_of_frame,
                  output fin_flag, output frame_opcode, output was_masked, input ready);
  modport sink   (input valid, input kind, input payload_byte, input last_of_frame,
                  input fin_flag, input frame_opcode, input was_masked, output ready);
endinterface

### rtl/websocket_frame_deframer_unit.sv
// WebSocket frame deframer: receive side byte stream to unmasked payload results.
//
// Channels: in_i carries one received stream byte per beat; out_o carries one
// result per beat (payload byte, empty-frame end, or reserved-bit reject),
// each with the FIN, opcode and mask flag of its frame.
// Throughput: one byte per cycle while the queue is not full, set by the parser;
// header bytes produce no result, so output beats are sparse there.
// Path: the edge that accepts a byte writes its result into the queue; the output
// register loads it from the queue head once that register is empty or being
// taken, and the result leaves on out_o from that register.
// Stall: when out_o is held off, results collect in a Depth-entry queue; the
// parser keeps taking bytes until the queue fills, then drops in_i.ready.
// Reset: rst_ni clears the parser to wait for header byte 0 and empties the
// queue and the output register; no clearing pass is needed.
// Depends on wsdf_pkg, wsdf_if, wsdf_front, wsdf_queue and wsdf_back.
module websocket_frame_deframer_unit #(
  parameter int unsigned QueueDepth = wsdf_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  wsdf_byte_if.sink     in_i,
  wsdf_result_if.source out_o
);

  logic             push;
  logic             pop;
  logic             full;
  logic             empty;
  wsdf_pkg::entry_t front_entry;
  wsdf_pkg::entry_t head_entry;

  wsdf_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_ready_i (!full),
    .push_o    (push),
    .entry_o   (front_entry)
  );

  wsdf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .full_o  (full),
    .pop_i   (pop),
    .entry_o (head_entry),
    .empty_o (empty)
  );

  wsdf_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .entry_i (head_entry),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

### rtl/wsdf_front.sv
// Front end: accepts stream bytes, walks the frame header and classifies each byte.
// Depends on wsdf_pkg and wsdf_byte_if.
module wsdf_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  wsdf_byte_if.sink       in_i,
  input  logic            q_ready_i,
  output logic            push_o,
  output wsdf_pkg::entry_t entry_o
);

  localparam logic [2:0] PhHead0  = 3'd0;
  localparam logic [2:0] PhLen    = 3'd1;
  localparam logic [2:0] PhExtLen = 3'd2;
  localparam logic [2:0] PhKey    = 3'd3;
  localparam logic [2:0] PhData   = 3'd4;

  logic [2:0]  phase_q, phase_d;
  logic        fin_q, fin_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        mask_q, mask_d;
  logic [3:0]  hdr_left_q, hdr_left_d;
  logic [63:0] len_acc_q, len_acc_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  key_idx_q, key_idx_d;
  logic [63:0] pay_left_q, pay_left_d;

  logic        fire;
  logic [7:0]  b;
  logic        len_known;
  logic [63:0] len_val;
  logic        mask_now;
  logic [7:0]  key_byte;

  assign in_i.ready = q_ready_i;
  assign fire       = in_i.valid && in_i.ready;
  assign b          = in_i.stream_byte;

  always_comb begin
    case (key_idx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d    = phase_q;
    fin_d      = fin_q;
    opcode_d   = opcode_q;
    mask_d     = mask_q;
    hdr_left_d = hdr_left_q;
    len_acc_d  = len_acc_q;
    key_d      = key_q;
    key_idx_d  = key_idx_q;
    pay_left_d = pay_left_q;
    len_known  = 1'b0;
    len_val    = 64'd0;
    mask_now   = mask_q;
    push_o     = 1'b0;
    entry_o        = '0;
    entry_o.kind   = wsdf_pkg::KindPayload;
    entry_o.fin    = fin_q;
    entry_o.opcode = opcode_q;

    if (fire) begin
      unique case (phase_q)
        PhLen: begin
          mask_now = b[7];
          mask_d   = b[7];
          if (b[6:0] <= wsdf_pkg::Len7Max) begin
            len_known = 1'b1;
            len_val   = {57'd0, b[6:0]};
          end else begin
            len_acc_d  = 64'd0;
            hdr_left_d = (b[6:0] == wsdf_pkg::Len16Code) ? wsdf_pkg::Ext16Bytes
                                                         : wsdf_pkg::Ext64Bytes;
            phase_d    = PhExtLen;
          end
        end
        PhExtLen: begin
          len_acc_d  = {len_acc_q[55:0], b};
          hdr_left_d = hdr_left_q - 4'd1;
          if (hdr_left_q == 4'd1) begin
            len_known = 1'b1;
            len_val   = len_acc_d;
          end
        end
        PhKey: begin
          key_d      = {key_q[23:0], b};
          hdr_left_d = hdr_left_q - 4'd1;
          if (hdr_left_q == 4'd1) begin
            if (pay_left_q == 64'd0) begin
              phase_d        = PhHead0;
              push_o         = 1'b1;
              entry_o.kind   = wsdf_pkg::KindEmpty;
              entry_o.masked = 1'b1;
            end else begin
              phase_d = PhData;
            end
          end
        end
        PhData: begin
          key_idx_d      = key_idx_q + 2'd1;
          pay_left_d     = pay_left_q - 64'd1;
          push_o         = 1'b1;
          entry_o.raw    = b;
          entry_o.key    = mask_q ? key_byte : 8'd0;
          entry_o.masked = mask_q;
          entry_o.last   = (pay_left_q == 64'd1);
          if (pay_left_q == 64'd1) begin
            phase_d = PhHead0;
          end
        end
        default: begin
          // Undefined phase codes fall back to header byte 0 as well.
          if ((b & wsdf_pkg::RsvMask) != 8'd0) begin
            phase_d        = PhHead0;
            push_o         = 1'b1;
            entry_o.kind   = wsdf_pkg::KindReject;
            entry_o.fin    = b[7];
            entry_o.opcode = b[3:0];
          end else begin
            fin_d    = b[7];
            opcode_d = b[3:0];
            phase_d  = PhLen;
          end
        end
      endcase

      // Length settled: go to the key, the payload, or close an empty frame.
      if (len_known) begin
        pay_left_d = len_val;
        key_idx_d  = 2'd0;
        if (mask_now) begin
          key_d      = 32'd0;
          hdr_left_d = wsdf_pkg::KeyBytes;
          phase_d    = PhKey;
        end else if (len_val == 64'd0) begin
          phase_d      = PhHead0;
          push_o       = 1'b1;
          entry_o.kind = wsdf_pkg::KindEmpty;
        end else begin
          phase_d = PhData;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhHead0;
      fin_q      <= 1'b0;
      opcode_q   <= 4'd0;
      mask_q     <= 1'b0;
      hdr_left_q <= 4'd0;
      len_acc_q  <= 64'd0;
      key_q      <= 32'd0;
      key_idx_q  <= 2'd0;
      pay_left_q <= 64'd0;
    end else begin
      phase_q    <= phase_d;
      fin_q      <= fin_d;
      opcode_q   <= opcode_d;
      mask_q     <= mask_d;
      hdr_left_q <= hdr_left_d;
      len_acc_q  <= len_acc_d;
      key_q      <= key_d;
      key_idx_q  <= key_idx_d;
      pay_left_q <= pay_left_d;
    end
  end

`ifndef SYNTHESIS
  a_hdr_left_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhExtLen || phase_q == PhKey) |-> hdr_left_q != 4'd0)
    else $error("header byte count empty in extended length or key phase");

  a_data_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhData) |-> pay_left_q != 64'd0)
    else $error("payload phase with no bytes left");

  a_reject_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && entry_o.kind == wsdf_pkg::KindReject) |-> (b & wsdf_pkg::RsvMask) != 8'd0)
    else $error("reject issued for a clean header byte");
`endif

endmodule

### rtl/wsdf_queue.sv
// Short FIFO of classified results between the parser and the output stage.
// Depends on wsdf_pkg.
module wsdf_queue #(
  parameter int unsigned Depth = wsdf_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  wsdf_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output wsdf_pkg::entry_t entry_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  wsdf_pkg::entry_t slots_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign entry_o = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full result queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from an empty result queue");
`endif

endmodule

### rtl/wsdf_back.sv
// Back end: unmasks queued results and holds them in the output register.
// Depends on wsdf_pkg and wsdf_result_if.
module wsdf_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  wsdf_pkg::entry_t entry_i,
  input  logic             empty_i,
  output logic             pop_o,
  wsdf_result_if.source    out_o
);

  logic       valid_q;
  logic [1:0] kind_q;
  logic [7:0] data_q;
  logic       last_q;
  logic       fin_q;
  logic [3:0] opcode_q;
  logic       masked_q;

  // Refill the output register when it is empty or being taken this cycle.
  assign pop_o = !empty_i && (!valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || out_o.ready) begin
      valid_q <= !empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q   <= entry_i.kind;
      data_q   <= entry_i.raw ^ entry_i.key;
      last_q   <= entry_i.last;
      fin_q    <= entry_i.fin;
      opcode_q <= entry_i.opcode;
      masked_q <= entry_i.masked;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.kind          = kind_q;
  assign out_o.payload_byte  = data_q;
  assign out_o.last_of_frame = last_q;
  assign out_o.fin_flag      = fin_q;
  assign out_o.frame_opcode  = opcode_q;
  assign out_o.was_masked    = masked_q;

`ifndef SYNTHESIS
  a_side_results_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && kind_q != wsdf_pkg::KindPayload) |-> (data_q == 8'd0 && !last_q))
    else $error("empty or reject result carries payload data");
`endif

endmodule

### tb/sv/tb_websocket_frame_deframer_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for websocket_frame_deframer_unit: drives frame streams byte by byte
// and checks every result beat against an in-bench frame parser. Needs wsdf_pkg, wsdf_if and the deframer unit.
module tb_websocket_frame_deframer_unit;

  typedef enum logic [2:0] {
    PhHead = 3'd0,
    PhLen  = 3'd1,
    PhExt  = 3'd2,
    PhKey  = 3'd3,
    PhData = 3'd4
  } parse_phase_e;

  typedef enum int {
    Form7,
    Form16,
    Form64
  } len_form_e;

  localparam logic [6:0] Len64Code = 7'd127;

  typedef struct {
    wsdf_pkg::kind_e kind;
    logic [7:0]      payload;
    logic            last;
    logic            fin;
    logic [3:0]      opcode;
    logic            masked;
  } deframe_result_t;

  typedef struct {
    logic [7:0] value;
    bit         drain_first;
  } stream_item_t;

  logic clk_i;
  logic rst_ni;

  wsdf_byte_if   byte_ch ();
  wsdf_result_if res_ch ();

  websocket_frame_deframer_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_ch),
    .out_o  (res_ch)
  );

  // Parser state mirrored in the bench.
  parse_phase_e rx_phase;
  logic         rx_fin;
  logic [3:0]   rx_opcode;
  logic         rx_masked;
  logic [3:0]   hdr_left;
  logic [63:0]  len_acc;
  logic [31:0]  rx_key;
  logic [1:0]   key_idx;
  logic [63:0]  data_left;

  deframe_result_t results_due[$];
  stream_item_t    stream_bytes[$];

  int  bytes_queued;
  int  bytes_accepted;
  int  results_seen;
  int  mismatch_count;
  bit  byte_taken;
  int  src_gap;
  int  snk_gap;
  int  hold_left;
  int  long_holds;
  int  next_hold_at;
  stream_item_t next_item;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic void record_result(wsdf_pkg::kind_e kind, logic [7:0] payload,
                                        logic last, logic fin, logic [3:0] opcode,
                                        logic masked);
    deframe_result_t r;
    r.kind    = kind;
    r.payload = payload;
    r.last    = last;
    r.fin     = fin;
    r.opcode  = opcode;
    r.masked  = masked;
    results_due.insert(results_due.size(), r);
  endfunction

  // Length known: go to the key, the payload, or close an empty frame.
  function automatic void length_settled(logic [63:0] len);
    data_left = len;
    key_idx   = 2'd0;
    if (rx_masked) begin
      rx_key   = 32'd0;
      hdr_left = wsdf_pkg::KeyBytes;
      rx_phase = PhKey;
    end else if (len == 64'd0) begin
      rx_phase = PhHead;
      record_result(wsdf_pkg::KindEmpty, 8'd0, 1'b0, rx_fin, rx_opcode, 1'b0);
    end else begin
      rx_phase = PhData;
    end
  endfunction

  function automatic void parse_stream_byte(logic [7:0] b);
    int         sh;
    logic [7:0] v;
    case (rx_phase)
      PhLen: begin
        rx_masked = b[7];
        if (b[6:0] <= wsdf_pkg::Len7Max) begin
          length_settled({57'd0, b[6:0]});
        end else begin
          len_acc  = 64'd0;
          hdr_left = (b[6:0] == wsdf_pkg::Len16Code) ? wsdf_pkg::Ext16Bytes
                                                      : wsdf_pkg::Ext64Bytes;
          rx_phase = PhExt;
        end
      end
      PhExt: begin
        len_acc  = {len_acc[55:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 4'd0) length_settled(len_acc);
      end
      PhKey: begin
        rx_key   = {rx_key[23:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 4'd0) begin
          if (data_left == 64'd0) begin
            rx_phase = PhHead;
            record_result(wsdf_pkg::KindEmpty, 8'd0, 1'b0, rx_fin, rx_opcode, 1'b1);
          end else begin
            rx_phase = PhData;
          end
        end
      end
      PhData: begin
        v = b;
        if (rx_masked) begin
          sh = 24 - 8 * int'(key_idx);
          v  = b ^ rx_key[sh +: 8];
        end
        key_idx   = key_idx + 2'd1;
        data_left = data_left - 64'd1;
        if (data_left == 64'd0) rx_phase = PhHead;
        record_result(wsdf_pkg::KindPayload, v, data_left == 64'd0, rx_fin, rx_opcode,
                      rx_masked);
      end
      default: begin
        rx_phase = PhHead;
        if ((b & wsdf_pkg::RsvMask) != 8'd0) begin
          record_result(wsdf_pkg::KindReject, 8'd0, 1'b0, b[7], b[3:0], 1'b0);
        end else begin
          rx_fin    = b[7];
          rx_opcode = b[3:0];
          rx_phase  = PhLen;
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  function automatic void push_byte(logic [7:0] value, bit drain_first);
    stream_item_t it;
    it.value       = value;
    it.drain_first = drain_first;
    stream_bytes.insert(stream_bytes.size(), it);
    bytes_queued++;
  endfunction

  function automatic void queue_frame(bit fin, logic [3:0] opcode, bit masked,
                                      len_form_e form, logic [63:0] len,
                                      logic [31:0] mkey, int data_cnt, bit drain_first);
    push_byte({fin, 3'b000, opcode}, drain_first);
    case (form)
      Form7: push_byte({masked, len[6:0]}, 1'b0);
      Form16: begin
        push_byte({masked, wsdf_pkg::Len16Code}, 1'b0);
        push_byte(len[15:8], 1'b0);
        push_byte(len[7:0], 1'b0);
      end
      default: begin
        push_byte({masked, Len64Code}, 1'b0);
        for (int i = 7; i >= 0; i--) push_byte(len[8*i +: 8], 1'b0);
      end
    endcase
    if (masked) for (int i = 3; i >= 0; i--) push_byte(mkey[8*i +: 8], 1'b0);
    for (int i = 0; i < data_cnt; i++) push_byte(8'($urandom), 1'b0);
  endfunction

  // Quiet stretches come and go; the tail of the run allows no random gaps.
  function automatic bit idle_allowed();
    return stream_bytes.size() > 250 && ((stream_bytes.size() / 160) % 3 != 0);
  endfunction

  // Result check, then byte prediction: a result never leaves on the edge that takes its byte.
  always @(posedge clk_i) begin
    deframe_result_t exp_r;
    if (rst_ni) begin
      if (res_ch.valid && res_ch.ready) begin
        results_seen++;
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("result with none due, kind %0d", res_ch.kind));
        end else begin
          exp_r = results_due.pop_front();
          if (res_ch.kind !== exp_r.kind)
            report_mismatch($sformatf("kind %0d, want %0d", res_ch.kind, exp_r.kind));
          if (res_ch.payload_byte !== exp_r.payload)
            report_mismatch($sformatf("payload_byte %02h, want %02h",
                                      res_ch.payload_byte, exp_r.payload));
          if (res_ch.last_of_frame !== exp_r.last)
            report_mismatch($sformatf("last_of_frame %0b, want %0b",
                                      res_ch.last_of_frame, exp_r.last));
          if (res_ch.fin_flag !== exp_r.fin)
            report_mismatch($sformatf("fin_flag %0b, want %0b", res_ch.fin_flag, exp_r.fin));
          if (res_ch.frame_opcode !== exp_r.opcode)
            report_mismatch($sformatf("frame_opcode %0h, want %0h",
                                      res_ch.frame_opcode, exp_r.opcode));
          if (res_ch.was_masked !== exp_r.masked)
            report_mismatch($sformatf("was_masked %0b, want %0b",
                                      res_ch.was_masked, exp_r.masked));
        end
      end
      byte_taken = byte_ch.valid && byte_ch.ready;
      if (byte_taken) begin
        bytes_accepted++;
        parse_stream_byte(byte_ch.stream_byte);
      end
    end
  end

  // Byte driver: hold an offered beat until taken, then advance or idle.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      byte_ch.valid <= 1'b0;
    end else if (!(byte_ch.valid && !byte_taken)) begin
      if (src_gap > 0) begin
        src_gap--;
        byte_ch.valid <= 1'b0;
      end else if (stream_bytes.size() > 0 &&
                   !(stream_bytes[0].drain_first && results_due.size() != 0)) begin
        next_item = stream_bytes.pop_front();
        byte_ch.valid       <= 1'b1;
        byte_ch.stream_byte <= next_item.value;
        if (idle_allowed() && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 8);
      end else begin
        byte_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus long hold-offs so the block fills and stops taking bytes.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else if (long_holds < 2 && results_seen >= next_hold_at) begin
      long_holds++;
      next_hold_at += 700;
      hold_left = 250;
      res_ch.ready <= 1'b0;
    end else if (snk_gap > 0) begin
      snk_gap--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
      if (idle_allowed() && $urandom_range(0, 5) == 0) snk_gap = $urandom_range(1, 8);
    end
  end

  initial begin
    int          pick;
    int          next_drain;
    bit          drain;
    logic [7:0]  noise;
    logic [63:0] len;
    len_form_e   form;

    rst_ni              = 1'b0;
    byte_ch.valid       = 1'b0;
    byte_ch.stream_byte = 8'd0;
    res_ch.ready        = 1'b0;
    rx_phase   = PhHead;
    rx_fin     = 1'b0;
    rx_opcode  = 4'd0;
    rx_masked  = 1'b0;
    hdr_left   = 4'd0;
    len_acc    = 64'd0;
    rx_key     = 32'd0;
    key_idx    = 2'd0;
    data_left  = 64'd0;
    byte_taken = 1'b0;
    src_gap    = 0;
    snk_gap    = 0;
    hold_left  = 0;
    long_holds = 0;
    next_hold_at = 300;

    // Directed: rejects, empty frames in the 7-bit and 16-bit forms, an all-ones key.
    push_byte(8'hFF, 1'b0);
    push_byte(8'h10, 1'b0);
    push_byte(8'h4A, 1'b0);
    queue_frame(1'b1, 4'h9, 1'b0, Form7, 64'd0, 32'd0, 0, 1'b0);
    queue_frame(1'b1, 4'hA, 1'b1, Form7, 64'd0, 32'h0000_0000, 0, 1'b0);
    queue_frame(1'b0, 4'h2, 1'b0, Form16, 64'd0, 32'd0, 0, 1'b0);
    queue_frame(1'b1, 4'h1, 1'b1, Form7, 64'd1, 32'hFFFF_FFFF, 1, 1'b0);

    next_drain = 400;
    while (bytes_queued < 1820) begin
      drain = 1'b0;
      if (bytes_queued >= next_drain) begin
        drain = 1'b1;
        next_drain += 450;
      end
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        noise = 8'($urandom);
        if ((noise & wsdf_pkg::RsvMask) == 8'd0) noise[6] = 1'b1;
        push_byte(noise, drain);
      end else begin
        pick = $urandom_range(0, 15);
        form = Form7;
        if (pick <= 9) begin
          len = 64'($urandom_range(0, 12));
        end else if (pick == 10) begin
          len = 64'd0;
        end else if (pick == 11) begin
          len = 64'($urandom_range(100, 125));
        end else if (pick == 12) begin
          form = Form16;
          len  = 64'($urandom_range(0, 300));
        end else if (pick == 13) begin
          form = Form16;
          len  = 64'($urandom_range(0, 20));
        end else begin
          form = Form64;
          len  = 64'($urandom_range(0, 40));
        end
        queue_frame(1'($urandom), 4'($urandom), 1'($urandom), form, len, $urandom,
                    int'(len), drain);
      end
    end
    // Close on a 64-bit length with the top bit set; it never runs out.
    len = {1'b1, 31'($urandom), 32'($urandom)};
    queue_frame(1'b1, 4'h2, 1'b1, Form64, len, $urandom, 100, 1'b0);

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_accepted < bytes_queued || results_due.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### websocket_frame_deframer_unit.f
rtl/wsdf_pkg.sv
rtl/wsdf_if.sv
rtl/wsdf_front.sv
rtl/wsdf_queue.sv
rtl/wsdf_back.sv
rtl/websocket_frame_deframer_unit.sv
tb/sv/tb_websocket_frame_deframer_unit.sv
